// ===== hdl/lpsm_pkg.sv =====
// Shared types and constants for the LRU page-to-slot mapper.
// Used by the controller, the datapath and the top level; no dependencies.
package lpsm_pkg;

   // Fixed field widths at the ports
   localparam int PAGE_W    = 32;
   localparam int SLOT_W    = 4;
   localparam int CFG_W     = 5;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // latch the request, restart the scan
      logic issue;    // read the slot at the scan counter, advance it
      logic finish;   // commit the update and present the result
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_last; // scan counter points at the last active slot
   } status_type;

endpackage

// ===== hdl/lpsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lpsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lpsm_ctrl.sv =====
// Controller for the LRU page-to-slot mapper: sequences scan, compare and commit.
// Depends on lpsm_pkg.
module lpsm_ctrl
   import lpsm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_LAST;
         end
         ST_LAST:   state_in = ST_FINISH;
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands and busy
   always_comb begin
      busy       = 1'b1;
      cmd.load   = 1'b0;
      cmd.issue  = 1'b0;
      cmd.finish = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN:   cmd.issue  = 1'b1;
         ST_LAST:   ;
         ST_FINISH: cmd.finish = 1'b1;
         default:   busy = 1'b1;
      endcase
   end

endmodule

// ===== hdl/lpsm_dp.sv =====
// Datapath for the LRU page-to-slot mapper: page RAM, valid bits, recency ranks,
// scan compare and the result registers. Depends on lpsm_pkg and lpsm_ram.
module lpsm_dp
   import lpsm_pkg::*;
#(
   parameter int NUM_SLOTS    = 16,
   parameter int PAGE_ID_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [PAGE_W-1:0]  req_page_id,
   input  logic               csr_wr_en,
   input  logic [CFG_W-1:0]   csr_wr_data,
   output logic               rsp_valid,
   output logic [SLOT_W-1:0]  rsp_slot_index,
   output logic               rsp_hit,
   output logic               rsp_evicted,
   output logic [PAGE_W-1:0]  rsp_evicted_page_id
);

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int WW = (CW > CFG_W) ? CW : CFG_W;
   localparam int SB = (PAGE_ID_BITS < PAGE_W) ? PAGE_ID_BITS : PAGE_W;

   logic [CFG_W-1:0] active_ff;
   logic [SB-1:0]    page_ff;
   logic [IW-1:0]    cnt_ff;
   logic             cmp_vld_ff;
   logic [IW-1:0]    cmp_idx_ff;
   logic             hit_ff;
   logic [IW-1:0]    hit_idx_ff;
   logic [IW-1:0]    old_rank_ff;
   logic [IW-1:0]    vic_idx_ff;
   logic             vic_valid_ff;
   logic [SB-1:0]    vic_page_ff;
   logic             valid_ff [NUM_SLOTS];
   logic [IW-1:0]    rank_ff  [NUM_SLOTS];
   logic             rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic             rsp_hit_ff;
   logic             rsp_evicted_ff;
   logic [PAGE_W-1:0] rsp_page_ff;

   logic [WW-1:0]    cfg_ext;
   logic [CW-1:0]    num_active;
   logic [SB-1:0]    rd_page;
   logic [IW-1:0]    slot;
   logic [IW-1:0]    old_rank;
   logic [IW-1:0]    top_rank;
   logic             ram_wr;

   // Clamp the configured slot count to 1..NUM_SLOTS
   always_comb begin
      cfg_ext = WW'(active_ff);
      if (cfg_ext == '0) begin
         num_active = CW'(1);
      end else if (cfg_ext > WW'(NUM_SLOTS)) begin
         num_active = CW'(NUM_SLOTS);
      end else begin
         num_active = CW'(cfg_ext);
      end
   end

   assign top_rank         = IW'(num_active - CW'(1));
   assign status.scan_last = (cnt_ff == top_rank);

   // Chosen slot and the rank it leaves
   assign slot     = hit_ff ? hit_idx_ff : vic_idx_ff;
   assign old_rank = hit_ff ? old_rank_ff : '0;
   assign ram_wr   = cmd.finish && !hit_ff;

   lpsm_ram #(
      .WIDTH (SB),
      .DEPTH (NUM_SLOTS)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (vic_idx_ff),
      .wr_data (page_ff),
      .rd_addr (cnt_ff),
      .rd_data (rd_page)
   );

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   // Latch the request and step the scan counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.issue;
         if (cmd.load) begin
            cnt_ff <= '0;
         end else if (cmd.issue) begin
            cnt_ff <= cnt_ff + IW'(1);
         end
      end
      cmp_idx_ff <= cnt_ff;
      if (cmd.load) begin
         page_ff <= req_page_id[SB-1:0];
      end
   end

   // Compare one slot per cycle; record hit and the oldest slot
   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (cmd.load) begin
         hit_ff <= 1'b0;
      end else if (cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_page == page_ff)) begin
         hit_ff <= 1'b1;
      end
      if (cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_page == page_ff)) begin
         hit_idx_ff  <= cmp_idx_ff;
         old_rank_ff <= rank_ff[cmp_idx_ff];
      end
      if (cmp_vld_ff && (rank_ff[cmp_idx_ff] == '0)) begin
         vic_idx_ff   <= cmp_idx_ff;
         vic_valid_ff <= valid_ff[cmp_idx_ff];
         vic_page_ff  <= rd_page;
      end
   end

   // Valid bits and recency ranks: clear on reset or config, update on commit
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (reset || csr_wr_en) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= IW'(i);
         end else if (cmd.finish) begin
            if (IW'(i) == slot) begin
               valid_ff[i] <= 1'b1;
               rank_ff[i]  <= top_rank;
            end else if ((CW'(i) < num_active) && (rank_ff[i] > old_rank)) begin
               rank_ff[i]  <= rank_ff[i] - IW'(1);
            end
         end
      end
   end

   // Result registers and strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_slot_ff    <= SLOT_W'(slot);
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= !hit_ff && vic_valid_ff;
         rsp_page_ff    <= (!hit_ff && vic_valid_ff) ? PAGE_W'(vic_page_ff) : '0;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot_index      = rsp_slot_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_evicted         = rsp_evicted_ff;
   assign rsp_evicted_page_id = rsp_page_ff;

endmodule

// ===== hdl/lru_page_slot_mapper.sv =====
// LRU page-to-slot mapper, top level. Depends on lpsm_pkg, lpsm_ctrl, lpsm_dp.
// Sequence: after start is accepted, the controller passes through ST_SCAN, which
// scans the active slots, one slot per cycle, then ST_LAST and ST_FINISH; the result
// strobe is registered from ST_FINISH. Start is taken only in ST_IDLE, which includes the strobe cycle.
// Reset (synchronous): 16 active slots, no mappings, slot i at recency rank i.
// Results cannot be stalled; each is shown for exactly one cycle.
module lru_page_slot_mapper
   import lpsm_pkg::*;
#(
   parameter int NUM_SLOTS    = 16,
   parameter int PAGE_ID_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [PAGE_W-1:0]  req_page_id,
   output logic               rsp_valid,
   output logic [SLOT_W-1:0]  rsp_slot_index,
   output logic               rsp_hit,
   output logic               rsp_evicted,
   output logic [PAGE_W-1:0]  rsp_evicted_page_id,
   input  logic               csr_wr_en,
   input  logic [CFG_W-1:0]   csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   lpsm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Storage, compare and result registers
   lpsm_dp #(
      .NUM_SLOTS    (NUM_SLOTS),
      .PAGE_ID_BITS (PAGE_ID_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_page_id         (req_page_id),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_hit             (rsp_hit),
      .rsp_evicted         (rsp_evicted),
      .rsp_evicted_page_id (rsp_evicted_page_id)
   );

endmodule
